### rtl/afs_pkg.sv
// Shared types and constants for the animation frame sequencer.
`default_nettype none

package afs_pkg;

    localparam int unsigned HEADER_BYTES = 8;

    localparam logic [1:0] CMD_ADVANCE     = 2'd0;
    localparam logic [1:0] CMD_HEADER      = 2'd1;
    localparam logic [1:0] CMD_SET_PENDING = 2'd2;

    localparam logic [1:0] HDR_OK          = 2'd0;
    localparam logic [1:0] HDR_UNSUPPORTED = 2'd1;
    localparam logic [1:0] HDR_TOO_LONG    = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] range_start;
        logic [15:0] range_end;
        logic [31:0] range_start_offset;
        logic        range_loop;
        logic        range_finish_current;
        logic [15:0] range_duration_override;
        logic [23:0] hdr_encoded_length;
        logic [15:0] hdr_duration;
        logic        hdr_is_raw;
    } afs_in_t;

    typedef struct packed {
        logic [15:0] frame_index;
        logic [31:0] frame_offset;
        logic        fetch_header;
        logic        last_frame;
        logic        switched;
        logic        looping;
        logic        finished;
        logic [1:0]  header_status;
    } afs_out_t;

endpackage

`default_nettype wire

### rtl/animation_frame_sequencer_unit.sv
// Top level of the animation frame sequencer: input register, core and result register.
`default_nettype none

// The sequencer takes one command item per cycle on the in channel and returns exactly
// one result item per command on the out channel. An accepted item sits in the input
// register, the core updates its range, frame and duration state in a single pass and
// the result is registered at the clock edge on which the item moves on, which waits
// only for a full result register that is not being drained. Throughput is one item
// per cycle; it drops only while the out side holds off and the result register
// cannot drain. The largest allowed encoded frame length is written through cfg_we
// and cfg_wdata and must only change while no item is in flight.
module animation_frame_sequencer_unit #(
    parameter int unsigned FRAME_HDR_BYTES = afs_pkg::HEADER_BYTES
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire afs_pkg::afs_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output afs_pkg::afs_out_t     out_data,
    input  wire logic             cfg_we,
    input  wire logic [23:0]      cfg_wdata
);
    import afs_pkg::*;

    afs_in_t     item_reg;
    logic        item_valid_reg;
    afs_out_t    result_reg;
    logic        result_valid_reg;
    logic [23:0] max_len_reg;
    afs_out_t    result;
    logic        step;

    // The held item moves on whenever the result register is empty or being drained.
    assign step      = item_valid_reg && (!result_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || step;
    assign out_valid = result_valid_reg;
    assign out_data  = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            max_len_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
                max_len_reg <= cfg_wdata;
            if (in_ready)
                item_valid_reg <= in_valid;
            if (step)
                result_valid_reg <= 1'b1;
            else if (out_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= in_data;
        if (step)
            result_reg <= result;
    end

    afs_core #(
        .FRAME_HDR_BYTES (FRAME_HDR_BYTES)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .item          (item_reg),
        .max_len_limit (max_len_reg),
        .result        (result)
    );

endmodule

`default_nettype wire

### rtl/afs_core.sv
// Sequencer state and the single-pass update for one command item.
`default_nettype none

module afs_core #(
    parameter int unsigned FRAME_HDR_BYTES = afs_pkg::HEADER_BYTES
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire afs_pkg::afs_in_t item,
    input  wire logic [23:0]      max_len_limit,
    output afs_pkg::afs_out_t     result
);
    import afs_pkg::*;

    logic [15:0] act_start_reg, act_start_next;
    logic [15:0] act_end_reg, act_end_next;
    logic [31:0] act_offset_reg, act_offset_next;
    logic        act_loop_reg, act_loop_next;
    logic        act_finish_reg, act_finish_next;
    logic [15:0] act_override_reg, act_override_next;
    logic [15:0] pend_start_reg, pend_start_next;
    logic [15:0] pend_end_reg, pend_end_next;
    logic [31:0] pend_offset_reg, pend_offset_next;
    logic        pend_loop_reg, pend_loop_next;
    logic        pend_finish_reg, pend_finish_next;
    logic [15:0] pend_override_reg, pend_override_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [15:0] cur_frame_reg, cur_frame_next;
    logic [31:0] cur_offset_reg, cur_offset_next;
    logic [15:0] ticks_left_reg, ticks_left_next;
    logic [23:0] cur_length_reg, cur_length_next;
    logic        fetch_by_switch_reg, fetch_by_switch_next;

    logic       last, sw, lp, fin;
    logic [1:0] status;

    assign last = (cur_frame_reg == act_end_reg);
    assign sw   = pend_valid_reg && (!pend_finish_reg || last);
    assign lp   = last && act_loop_reg && !pend_valid_reg;
    assign fin  = last && !(sw || lp);

    always_comb
    begin
        if (!item.hdr_is_raw && (max_len_limit == 24'd0))
            status = HDR_UNSUPPORTED;
        else if (!item.hdr_is_raw && (item.hdr_encoded_length > max_len_limit))
            status = HDR_TOO_LONG;
        else
            status = HDR_OK;
    end

    always_comb
    begin
        act_start_next       = act_start_reg;
        act_end_next         = act_end_reg;
        act_offset_next      = act_offset_reg;
        act_loop_next        = act_loop_reg;
        act_finish_next      = act_finish_reg;
        act_override_next    = act_override_reg;
        pend_start_next      = pend_start_reg;
        pend_end_next        = pend_end_reg;
        pend_offset_next     = pend_offset_reg;
        pend_loop_next       = pend_loop_reg;
        pend_finish_next     = pend_finish_reg;
        pend_override_next   = pend_override_reg;
        pend_valid_next      = pend_valid_reg;
        cur_frame_next       = cur_frame_reg;
        cur_offset_next      = cur_offset_reg;
        ticks_left_next      = ticks_left_reg;
        cur_length_next      = cur_length_reg;
        fetch_by_switch_next = fetch_by_switch_reg;
        result               = '0;

        unique case (item.command)
            CMD_SET_PENDING:
            begin
                pend_start_next    = item.range_start;
                pend_end_next      = item.range_end;
                pend_offset_next   = item.range_start_offset;
                pend_loop_next     = item.range_loop;
                pend_finish_next   = item.range_finish_current;
                pend_override_next = item.range_duration_override;
                pend_valid_next    = 1'b1;
            end
            CMD_ADVANCE:
            begin
                result.last_frame = last;
                result.switched   = sw;
                result.looping    = lp;
                result.finished   = fin;
                if (sw)
                begin
                    act_start_next       = pend_start_reg;
                    act_end_next         = pend_end_reg;
                    act_offset_next      = pend_offset_reg;
                    act_loop_next        = pend_loop_reg;
                    act_finish_next      = pend_finish_reg;
                    act_override_next    = pend_override_reg;
                    pend_valid_next      = 1'b0;
                    cur_frame_next       = pend_start_reg;
                    cur_offset_next      = pend_offset_reg;
                    result.fetch_header  = 1'b1;
                    fetch_by_switch_next = 1'b1;
                end
                else if (lp)
                begin
                    // Looping parks a copy of the active range in the pending slot.
                    pend_start_next      = act_start_reg;
                    pend_end_next        = act_end_reg;
                    pend_offset_next     = act_offset_reg;
                    pend_loop_next       = act_loop_reg;
                    pend_finish_next     = act_finish_reg;
                    pend_override_next   = act_override_reg;
                    cur_frame_next       = act_start_reg;
                    cur_offset_next      = act_offset_reg;
                    result.fetch_header  = 1'b1;
                    fetch_by_switch_next = 1'b0;
                end
                else if (!fin)
                begin
                    cur_frame_next  = cur_frame_reg + 16'd1;
                    ticks_left_next = ticks_left_reg - 16'd1;
                    if (ticks_left_reg == 16'd1)
                    begin
                        cur_offset_next = cur_offset_reg + 32'(FRAME_HDR_BYTES)
                                          + {8'd0, cur_length_reg};
                        result.fetch_header  = 1'b1;
                        fetch_by_switch_next = 1'b0;
                    end
                end
            end
            CMD_HEADER:
            begin
                cur_length_next      = item.hdr_encoded_length;
                result.header_status = status;
                if (status == HDR_OK)
                    ticks_left_next = fetch_by_switch_reg ? act_override_reg
                                                          : item.hdr_duration;
                fetch_by_switch_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        result.frame_index  = cur_frame_next;
        result.frame_offset = cur_offset_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_start_reg       <= '0;
            act_end_reg         <= '0;
            act_offset_reg      <= '0;
            act_loop_reg        <= 1'b0;
            act_finish_reg      <= 1'b0;
            act_override_reg    <= '0;
            pend_start_reg      <= '0;
            pend_end_reg        <= '0;
            pend_offset_reg     <= '0;
            pend_loop_reg       <= 1'b0;
            pend_finish_reg     <= 1'b0;
            pend_override_reg   <= '0;
            pend_valid_reg      <= 1'b0;
            cur_frame_reg       <= '0;
            cur_offset_reg      <= '0;
            ticks_left_reg      <= '0;
            cur_length_reg      <= '0;
            fetch_by_switch_reg <= 1'b0;
        end
        else if (step)
        begin
            act_start_reg       <= act_start_next;
            act_end_reg         <= act_end_next;
            act_offset_reg      <= act_offset_next;
            act_loop_reg        <= act_loop_next;
            act_finish_reg      <= act_finish_next;
            act_override_reg    <= act_override_next;
            pend_start_reg      <= pend_start_next;
            pend_end_reg        <= pend_end_next;
            pend_offset_reg     <= pend_offset_next;
            pend_loop_reg       <= pend_loop_next;
            pend_finish_reg     <= pend_finish_next;
            pend_override_reg   <= pend_override_next;
            pend_valid_reg      <= pend_valid_next;
            cur_frame_reg       <= cur_frame_next;
            cur_offset_reg      <= cur_offset_next;
            ticks_left_reg      <= ticks_left_next;
            cur_length_reg      <= cur_length_next;
            fetch_by_switch_reg <= fetch_by_switch_next;
        end
    end

    // A switch consumes the pending range and marks the next header as switch-driven.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && result.switched |=> !pend_valid_reg && fetch_by_switch_reg)
        else $error("switch did not consume the pending range");

    assert property (@(posedge clk) disable iff (!rst_n)
        step && result.looping |=> !pend_valid_reg && !fetch_by_switch_reg
                                   && (cur_frame_reg == act_start_reg))
        else $error("loop did not restart the active range");

    assert property (@(posedge clk) disable iff (!rst_n)
        step && (item.command == CMD_SET_PENDING) |=> pend_valid_reg)
        else $error("pending range not marked valid");

    assert property (@(posedge clk) disable iff (!rst_n)
        step && result.finished |=> $stable(cur_frame_reg) && $stable(ticks_left_reg))
        else $error("finished advance changed the sequencer state");

    assert property (@(posedge clk) disable iff (!rst_n)
        step && (item.command == CMD_HEADER) |=> !fetch_by_switch_reg)
        else $error("header arrival left the switch mark set");

endmodule

`default_nettype wire

### test/tb_animation_frame_sequencer_unit.sv
// Self-checking testbench for the animation frame sequencer unit.
module tb_animation_frame_sequencer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import afs_pkg::*;

    // Command code that the block must treat as a no-op.
    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int RANDOM_ITEMS = 1800;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [15:0] start_idx;
        logic [15:0] end_idx;
        logic [31:0] offset;
        logic        loop_on;
        logic        finish_cur;
        logic [15:0] override_dur;
    } frame_range_t;

    typedef struct {
        bit          is_cfg;
        logic [23:0] cfg_value;
        afs_in_t     item;
        bit          typed;
        afs_out_t    result;
    } stim_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    afs_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    afs_out_t out_data;
    logic     cfg_we = 1'b0;
    logic [23:0] cfg_wdata = '0;

    // Predictor state of the sequencer.
    frame_range_t live_range;
    frame_range_t queued_range;
    logic         queued_live;
    logic [15:0]  shown_frame;
    logic [31:0]  shown_offset;
    logic [15:0]  ticks_to_go;
    logic [23:0]  payload_len;
    logic         fetched_for_switch;
    logic [23:0]  max_len;

    afs_out_t  expected_results[$];
    stim_row_t stimulus_table[$];
    int        mismatches = 0;
    int        send_calm = 0;
    int        recv_calm = 0;
    bit        header_due = 1'b0;

    animation_frame_sequencer_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic afs_out_t sequencer_next(afs_in_t item);
        afs_out_t r;
        logic at_last;
        logic do_switch;
        logic do_loop;
        logic done;
        logic [1:0] status;
        r = '0;
        case (item.command)
            CMD_SET_PENDING:
            begin
                queued_range.start_idx    = item.range_start;
                queued_range.end_idx      = item.range_end;
                queued_range.offset       = item.range_start_offset;
                queued_range.loop_on      = item.range_loop;
                queued_range.finish_cur   = item.range_finish_current;
                queued_range.override_dur = item.range_duration_override;
                queued_live = 1'b1;
            end
            CMD_ADVANCE:
            begin
                at_last   = shown_frame == live_range.end_idx;
                do_switch = queued_live && (!queued_range.finish_cur || at_last);
                do_loop   = at_last && live_range.loop_on && !queued_live;
                done      = at_last && !(do_switch || do_loop);
                r.last_frame = at_last;
                r.switched   = do_switch;
                r.looping    = do_loop;
                r.finished   = done;
                if (do_switch || do_loop)
                begin
                    // A loop goes through the pending slot: it ends up holding a copy.
                    if (do_loop)
                        queued_range = live_range;
                    else
                        queued_live = 1'b0;
                    live_range   = queued_range;
                    shown_frame  = live_range.start_idx;
                    shown_offset = live_range.offset;
                    r.fetch_header = 1'b1;
                    fetched_for_switch = do_switch;
                end
                else if (!done)
                begin
                    shown_frame = shown_frame + 16'd1;
                    ticks_to_go = ticks_to_go - 16'd1;
                    if (ticks_to_go == 16'd0)
                    begin
                        shown_offset = shown_offset + 32'(HEADER_BYTES) + 32'(payload_len);
                        r.fetch_header = 1'b1;
                        fetched_for_switch = 1'b0;
                    end
                end
            end
            CMD_HEADER:
            begin
                payload_len = item.hdr_encoded_length;
                status = HDR_OK;
                if (!item.hdr_is_raw)
                begin
                    if (max_len == 24'd0)
                        status = HDR_UNSUPPORTED;
                    else if (payload_len > max_len)
                        status = HDR_TOO_LONG;
                end
                if (status == HDR_OK)
                    ticks_to_go = fetched_for_switch ? live_range.override_dur
                                                     : item.hdr_duration;
                fetched_for_switch = 1'b0;
                r.header_status = status;
            end
            default: ;
        endcase
        r.frame_index  = shown_frame;
        r.frame_offset = shown_offset;
        return r;
    endfunction

    // Gaps are random, with occasional stretches of back-to-back items.
    function automatic int pick_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    function automatic afs_in_t mk_cmd(logic [1:0] cmd, logic [15:0] rstart,
                                       logic [15:0] rend, logic [31:0] roff, logic rloop,
                                       logic rfin, logic [15:0] rovr, logic [23:0] len,
                                       logic [15:0] dur, logic raw);
        afs_in_t it;
        it.command                 = cmd;
        it.range_start             = rstart;
        it.range_end               = rend;
        it.range_start_offset      = roff;
        it.range_loop              = rloop;
        it.range_finish_current    = rfin;
        it.range_duration_override = rovr;
        it.hdr_encoded_length      = len;
        it.hdr_duration            = dur;
        it.hdr_is_raw              = raw;
        return it;
    endfunction

    function automatic afs_out_t mk_res(logic [15:0] frame, logic [31:0] off, logic fetch,
                                        logic last, logic sw, logic lp, logic fin,
                                        logic [1:0] status);
        afs_out_t r;
        r.frame_index   = frame;
        r.frame_offset  = off;
        r.fetch_header  = fetch;
        r.last_frame    = last;
        r.switched      = sw;
        r.looping       = lp;
        r.finished      = fin;
        r.header_status = status;
        return r;
    endfunction

    function automatic string fmt_result(afs_out_t r);
        return $sformatf("frame=%h off=%h fetch=%b last=%b sw=%b loop=%b fin=%b status=%0d",
                         r.frame_index, r.frame_offset, r.fetch_header, r.last_frame,
                         r.switched, r.looping, r.finished, r.header_status);
    endfunction

    // Well-formed command sequences with random content, plus some pure noise.
    function automatic afs_in_t random_command();
        afs_in_t it;
        logic [127:0] noise;
        int pick;
        noise = {$urandom, $urandom, $urandom, $urandom};
        it = noise[$bits(afs_in_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 6)
            return it;
        if (header_due ? pick < 85 : pick < 11)
        begin
            it.command = CMD_HEADER;
            it.hdr_is_raw = $urandom_range(0, 9) < 6;
            case ($urandom_range(0, 4))
                0: it.hdr_encoded_length = max_len;
                1: it.hdr_encoded_length = max_len + 24'd1;
                2: it.hdr_encoded_length = max_len - 24'(max_len != 24'd0);
                3: it.hdr_encoded_length = 24'($urandom_range(0, 64));
                default: ;
            endcase
            if ($urandom_range(0, 19) != 0)
                it.hdr_duration = 16'($urandom_range(1, 4));
        end
        else if (pick < (header_due ? 90 : 24))
        begin
            it.command = CMD_SET_PENDING;
            if ($urandom_range(0, 3) != 0)
                it.range_start = shown_frame + 16'($urandom_range(0, 6));
            if ($urandom_range(0, 9) != 0)
                it.range_end = it.range_start + 16'($urandom_range(0, 5));
            if ($urandom_range(0, 9) != 0)
                it.range_duration_override = 16'($urandom_range(1, 4));
        end
        else
        begin
            it.command = CMD_ADVANCE;
        end
        return it;
    endfunction

    task automatic step_row(input afs_in_t item);
        stim_row_t row;
        row.is_cfg = 1'b0;
        row.cfg_value = '0;
        row.item = item;
        row.typed = 1'b0;
        row.result = '0;
        stimulus_table.push_back(row);
    endtask

    task automatic known_row(input afs_in_t item, input afs_out_t result);
        stim_row_t row;
        row.is_cfg = 1'b0;
        row.cfg_value = '0;
        row.item = item;
        row.typed = 1'b1;
        row.result = result;
        stimulus_table.push_back(row);
    endtask

    task automatic cfg_row(input logic [23:0] value);
        stim_row_t row;
        row.is_cfg = 1'b1;
        row.cfg_value = value;
        row.item = '0;
        row.typed = 1'b0;
        row.result = '0;
        stimulus_table.push_back(row);
    endtask

    task automatic send_item(input afs_in_t item, input bit typed, input afs_out_t known);
        int gap;
        afs_out_t predicted;
        gap = pick_gap(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predicted = sequencer_next(item);
        expected_results.push_back(typed ? known : predicted);
        header_due = predicted.fetch_header || (header_due && item.command != CMD_HEADER);
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_length(input logic [23:0] value);
        wait_all_results();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        max_len = value;
    endtask

    task automatic note_mismatch(input string what, input afs_out_t want, input afs_out_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s\n  expected %s\n  actual   %s", $realtime, what,
                     fmt_result(want), fmt_result(got));
    endtask

    task automatic check_result(input afs_out_t got);
        afs_out_t want;
        if (expected_results.size() == 0)
        begin
            note_mismatch("result with no item outstanding", '0, got);
            return;
        end
        want = expected_results.pop_front();
        if (got.frame_index !== want.frame_index || got.frame_offset !== want.frame_offset ||
            got.fetch_header !== want.fetch_header || got.last_frame !== want.last_frame ||
            got.switched !== want.switched || got.looping !== want.looping ||
            got.finished !== want.finished || got.header_status !== want.header_status)
            note_mismatch("result mismatch", want, got);
    endtask

    // Result side: stall for a random number of cycles, then take one item.
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = pick_gap(recv_calm);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            check_result(out_data);
        end
    end

    initial
    begin
        afs_in_t adv;
        int sent;
        logic [23:0] phase_max;

        live_range = '0;
        queued_range = '0;
        queued_live = 1'b0;
        shown_frame = '0;
        shown_offset = '0;
        ticks_to_go = '0;
        payload_len = '0;
        fetched_for_switch = 1'b0;
        max_len = '0;

        adv = mk_cmd(CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // Out of reset the active range is frame 0 only and nothing loops: finished.
        known_row(adv, mk_res(16'd0, 32'd0, 0, 1, 0, 0, 1, HDR_OK));
        known_row(mk_cmd(CMD_HEADER, 0, 0, 0, 0, 0, 0, 24'd5, 16'd3, 1'b0),
                  mk_res(16'd0, 32'd0, 0, 0, 0, 0, 0, HDR_UNSUPPORTED));
        known_row(mk_cmd(CMD_HEADER, 0, 0, 0, 0, 0, 0, 24'hFFFFFF, 16'hFFFF, 1'b1),
                  mk_res(16'd0, 32'd0, 0, 0, 0, 0, 0, HDR_OK));
        known_row(mk_cmd(CMD_RESERVED, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 1, 1, 16'hFFFF,
                         24'hFFFFFF, 16'hFFFF, 1),
                  mk_res(16'd0, 32'd0, 0, 0, 0, 0, 0, HDR_OK));
        // Range that straddles the frame index wrap, near the top of the offset space.
        known_row(mk_cmd(CMD_SET_PENDING, 16'hFFFE, 16'h0001, 32'hFFFFFFF0, 1, 0, 16'd2,
                         0, 0, 0),
                  mk_res(16'd0, 32'd0, 0, 0, 0, 0, 0, HDR_OK));
        step_row(adv);
        step_row(mk_cmd(CMD_HEADER, 0, 0, 0, 0, 0, 0, 24'h10, 16'd9, 1'b1));
        step_row(adv);
        step_row(adv);
        step_row(mk_cmd(CMD_HEADER, 0, 0, 0, 0, 0, 0, 24'd0, 16'd1, 1'b1));
        step_row(adv);
        step_row(adv);
        cfg_row(24'd1);
        step_row(mk_cmd(CMD_HEADER, 0, 0, 0, 0, 0, 0, 24'd1, 16'd0, 1'b0));
        step_row(mk_cmd(CMD_HEADER, 0, 0, 0, 0, 0, 0, 24'd2, 16'd5, 1'b0));
        step_row(mk_cmd(CMD_SET_PENDING, 16'd10, 16'd12, 32'h100, 0, 1, 16'd0, 0, 0, 0));
        step_row(adv);
        cfg_row(24'hFFFFFF);
        step_row(mk_cmd(CMD_HEADER, 0, 0, 0, 0, 0, 0, 24'hFFFFFF, 16'd1, 1'b0));
        step_row(adv);
        step_row(adv);
        step_row(mk_cmd(CMD_HEADER, 0, 0, 0, 0, 0, 0, 24'd4, 16'd7, 1'b1));
        step_row(adv);
        step_row(adv);
        step_row(adv);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stimulus_table[i])
        begin
            if (stimulus_table[i].is_cfg)
                write_max_length(stimulus_table[i].cfg_value);
            else
                send_item(stimulus_table[i].item, stimulus_table[i].typed,
                          stimulus_table[i].result);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent % 300 == 150)
            begin
                case (sent / 300)
                    0: phase_max = 24'hFFFFFF;
                    1: phase_max = 24'd0;
                    2: phase_max = 24'($urandom_range(2, 24'hFFFFFE));
                    3: phase_max = 24'd1;
                    default: phase_max = 24'($urandom_range(0, 1000));
                endcase
                write_max_length(phase_max);
            end
            else if (sent == 900)
            begin
                wait_all_results();
            end
            adv = random_command();
            send_item(adv, 1'b0, '0);
            if (adv.command != CMD_RESERVED)
                sent++;
        end

        wait_all_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
